@@ rtl/image_convolution_border_clamp_macros.svh @@
// Assertion macros for the convolution block
`ifndef IMAGE_CONVOLUTION_BORDER_CLAMP_MACROS_SVH
`define IMAGE_CONVOLUTION_BORDER_CLAMP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ICBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ICBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/icbc_pkg.sv @@
// Shared types and codes for the convolution block
package icbc_pkg;
	localparam int ACC_W = 32;

	localparam logic [1:0] MODE_COEF  = 2'd0;
	localparam logic [1:0] MODE_PIXEL = 2'd1;
	localparam logic [1:0] MODE_DRAIN = 2'd2;

	localparam logic [1:0] REG_ORDER  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_DIV    = 2'd3;

	localparam logic [7:0] PIX_MAX = 8'd255;

	typedef struct packed {
		logic                    start;
		logic signed [ACC_W-1:0] dividend;
		logic signed [15:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] pix;
	} div_rsp_t;
endpackage

@@ rtl/icbc_if.sv @@
// Input and output stream interfaces
interface icbc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] in_value;
	modport source (output valid, mode, in_value, input ready);
	modport sink (input valid, mode, in_value, output ready);
endinterface

interface icbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_pixel;
	logic [9:0] out_row;
	logic [9:0] out_col;
	logic       out_last;
	logic       div_zero;
	modport source (output valid, out_pixel, out_row, out_col, out_last, div_zero,
		input ready);
	modport sink (input valid, out_pixel, out_row, out_col, out_last, div_zero,
		output ready);
endinterface

@@ rtl/image_convolution_border_clamp.sv @@
// Top level: line memory, kernel memory, serial MAC and emit control
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    mode, in_value
//  out_ch    out  valid/ready    out_pixel, out_row, out_col, out_last, div_zero
//  cfg       in   cfg_we         cfg_index, cfg_data
//
// Coefficient load: stays in ST_IDLE. Pixel or drain with no result: ST_CHECK, then ST_IDLE.
// Border result: ST_CHECK, ST_BRD, ST_DONE. Interior result with zero divisor: ST_CHECK, ST_DONE.
// Interior result: ST_CHECK, then ST_MAC with one line-memory read per tap, ST_MACW for the
// product drain and ST_DIV for the 32-step divider, then ST_DONE.
// Reset clears control state only; memories hold garbage until written.
// A result waiting on out_ch holds the next result in ST_DONE, which stalls input.
module image_convolution_border_clamp #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_ORDER  = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	icbc_in_if.sink     in_ch,
	icbc_out_if.source  out_ch
);
	import icbc_pkg::*;

	localparam int CB   = $clog2(MAX_WIDTH);
	localparam int RB1  = $clog2(MAX_HEIGHT + 1);
	localparam int WB1  = $clog2(MAX_WIDTH + 1);
	localparam int MB   = (WB1 > RB1) ? WB1 : RB1;
	localparam int XW   = (MB > 11) ? MB : 11;
	localparam int SB   = $clog2(MAX_ORDER);
	localparam int LD   = MAX_ORDER * MAX_WIDTH;
	localparam int LA   = $clog2(LD);
	localparam int KD   = MAX_ORDER * MAX_ORDER;
	localparam int KA   = $clog2(KD);
	localparam int NNB  = $clog2(KD + 1);
	localparam int LB   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int TOPO = (MAX_ORDER - 1) | 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_BRD   = 7'b0000100,
		ST_MAC   = 7'b0001000,
		ST_MACW  = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [3:0]         ko_q;
	logic [10:0]        iw_q, ih_q;
	logic signed [15:0] dv_q;

	logic [3:0]     n_odd, n_eff, rad;
	logic [XW-1:0]  iw_x, ih_x;
	logic [WB1-1:0] w_eff;
	logic [RB1-1:0] h_eff;
	logic [NNB-1:0] nn;
	logic [LB-1:0]  total_q, rad_w_q;

	logic [KA-1:0]  coef_q;
	logic [RB1-1:0] in_row_q, emit_row_q;
	logic [CB-1:0]  in_col_q, emit_col_q;
	logic [SB-1:0]  in_slot_q, emit_slot_q;
	logic [LB-1:0]  in_lin_q, emit_lin_q;

	logic [SB-1:0]  wslot_q;
	logic [CB-1:0]  wcol_q;
	logic [3:0]     kr_q, kc_q;
	logic [KA-1:0]  kidx_q;

	logic [7:0]         lmem [LD];
	logic signed [15:0] kmem [KD];
	logic [LA-1:0]      raddr;
	logic [7:0]         ldat_s1;
	logic signed [15:0] kdat_s1;
	logic               issue_s1, prod_vld_s2;
	logic signed [24:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic [7:0] res_pix_q;
	logic       res_dz_q;

	logic out_valid_q;
	logic [7:0] out_pix_q;
	logic [9:0] out_row_q, out_col_q;
	logic       out_last_q, out_dz_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_xfer, px_write, out_load, restart;
	logic [LB:0] need;
	logic        emit_ok, border;
	logic [SB:0] slot_tmp;
	logic [SB-1:0] wslot_start;

	// effective geometry
	always_comb begin
		n_odd = ko_q | 4'd1;
		if (n_odd < 4'd3)
			n_eff = 4'd3;
		else if (n_odd > 4'(TOPO))
			n_eff = 4'(TOPO);
		else
			n_eff = n_odd;
		rad  = n_eff >> 1;
		iw_x = XW'(iw_q);
		ih_x = XW'(ih_q);
		if (iw_q == '0)
			w_eff = WB1'(1);
		else if (iw_x > XW'(MAX_WIDTH))
			w_eff = WB1'(MAX_WIDTH);
		else
			w_eff = WB1'(iw_x);
		if (ih_q == '0)
			h_eff = RB1'(1);
		else if (ih_x > XW'(MAX_HEIGHT))
			h_eff = RB1'(MAX_HEIGHT);
		else
			h_eff = RB1'(ih_x);
		nn = NNB'(NNB'(n_eff) * NNB'(n_eff));
	end

	always_ff @(posedge clk) begin
		total_q <= LB'(LB'(w_eff) * LB'(h_eff));
		rad_w_q <= LB'(LB'(rad) * LB'(w_eff));
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign px_write    = in_xfer && in_ch.mode == MODE_PIXEL && in_row_q < h_eff;
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);
	assign restart     = out_load && (emit_lin_q + 1'b1 == total_q);

	always_comb begin
		need = (LB+1)'(emit_lin_q) + (LB+1)'(rad_w_q) + (LB+1)'(rad) + 1'b1;
		if (need > (LB+1)'(total_q))
			need = (LB+1)'(total_q);
		emit_ok = (emit_lin_q < total_q) && ((LB+1)'(in_lin_q) >= need);
		border  = (emit_row_q < RB1'(rad)) || (emit_col_q < CB'(rad)) ||
			((emit_row_q + RB1'(rad)) >= h_eff) ||
			((WB1'(emit_col_q) + WB1'(rad)) >= w_eff);
		slot_tmp = (SB+1)'(emit_slot_q) + (SB+1)'(MAX_ORDER) - (SB+1)'(rad);
		if (slot_tmp >= (SB+1)'(MAX_ORDER))
			slot_tmp = slot_tmp - (SB+1)'(MAX_ORDER);
		wslot_start = slot_tmp[SB-1:0];
	end

	always_comb begin
		if (state_q == ST_MAC)
			raddr = LA'(LA'(wslot_q) * LA'(MAX_WIDTH)) + LA'(wcol_q);
		else
			raddr = LA'(LA'(emit_slot_q) * LA'(MAX_WIDTH)) + LA'(emit_col_q);
	end

	// memories
	always_ff @(posedge clk) begin
		if (px_write)
			lmem[LA'(LA'(in_slot_q) * LA'(MAX_WIDTH)) + LA'(in_col_q)] <= in_ch.in_value[7:0];
		ldat_s1 <= lmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (in_xfer && in_ch.mode == MODE_COEF)
			kmem[coef_q] <= in_ch.in_value;
		kdat_s1 <= kmem[kidx_q];
	end

	// config and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ko_q        <= 4'd3;
			iw_q        <= 11'd640;
			ih_q        <= 11'd480;
			dv_q        <= 16'sd1;
			coef_q      <= '0;
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			in_lin_q    <= '0;
			emit_row_q  <= '0;
			emit_col_q  <= '0;
			emit_slot_q <= '0;
			emit_lin_q  <= '0;
		end else begin
			if (in_xfer && in_ch.mode == MODE_COEF) begin
				if (NNB'(coef_q) + 1'b1 >= nn)
					coef_q <= '0;
				else
					coef_q <= coef_q + 1'b1;
			end
			if (px_write) begin
				in_lin_q <= in_lin_q + 1'b1;
				if (WB1'(in_col_q) + 1'b1 >= w_eff) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 1'b1;
					in_slot_q <= (in_slot_q == SB'(MAX_ORDER - 1)) ? '0 : in_slot_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (out_load) begin
				emit_lin_q <= emit_lin_q + 1'b1;
				if (WB1'(emit_col_q) + 1'b1 >= w_eff) begin
					emit_col_q  <= '0;
					emit_row_q  <= emit_row_q + 1'b1;
					emit_slot_q <= (emit_slot_q == SB'(MAX_ORDER - 1)) ? '0 :
						emit_slot_q + 1'b1;
				end else begin
					emit_col_q <= emit_col_q + 1'b1;
				end
			end
			if (restart || (cfg_we && cfg_index != REG_DIV)) begin
				in_row_q    <= '0;
				in_col_q    <= '0;
				in_slot_q   <= '0;
				in_lin_q    <= '0;
				emit_row_q  <= '0;
				emit_col_q  <= '0;
				emit_slot_q <= '0;
				emit_lin_q  <= '0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ORDER: begin
						ko_q   <= cfg_data[3:0];
						coef_q <= '0;
					end
					REG_WIDTH:  iw_q <= cfg_data[10:0];
					REG_HEIGHT: ih_q <= cfg_data[10:0];
					REG_DIV:    dv_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_s1    <= 1'b0;
			prod_vld_s2 <= 1'b0;
		end else begin
			issue_s1    <= (state_q == ST_MAC);
			prod_vld_s2 <= issue_s1;
			unique case (state_q)
				ST_IDLE:
					if (in_xfer && (in_ch.mode == MODE_PIXEL || in_ch.mode == MODE_DRAIN))
						state_q <= ST_CHECK;
				ST_CHECK:
					if (!emit_ok)
						state_q <= ST_IDLE;
					else if (border)
						state_q <= ST_BRD;
					else if (dv_q == '0)
						state_q <= ST_DONE;
					else
						state_q <= ST_MAC;
				ST_BRD: state_q <= ST_DONE;
				ST_MAC:
					if (kr_q == n_eff - 1'b1 && kc_q == n_eff - 1'b1)
						state_q <= ST_MACW;
				ST_MACW:
					if (!issue_s1 && !prod_vld_s2)
						state_q <= ST_DIV;
				ST_DIV:
					if (div_rsp.done)
						state_q <= ST_DONE;
				ST_DONE:
					if (out_load)
						state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window walk and accumulate
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			wslot_q  <= wslot_start;
			wcol_q   <= emit_col_q - CB'(rad);
			kr_q     <= '0;
			kc_q     <= '0;
			kidx_q   <= '0;
			acc_q    <= '0;
			res_pix_q <= 8'd0;
			res_dz_q  <= !border && dv_q == '0;
		end else if (state_q == ST_MAC) begin
			kidx_q <= kidx_q + 1'b1;
			if (kc_q == n_eff - 1'b1) begin
				kc_q    <= '0;
				kr_q    <= kr_q + 1'b1;
				wcol_q  <= emit_col_q - CB'(rad);
				wslot_q <= (wslot_q == SB'(MAX_ORDER - 1)) ? '0 : wslot_q + 1'b1;
			end else begin
				kc_q   <= kc_q + 1'b1;
				wcol_q <= wcol_q + 1'b1;
			end
		end
		if (issue_s1)
			prod_s2 <= $signed({1'b0, ldat_s1}) * kdat_s1;
		if (prod_vld_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
		if (state_q == ST_BRD)
			res_pix_q <= ldat_s1;
		if (state_q == ST_DIV && div_rsp.done)
			res_pix_q <= div_rsp.pix;
	end

	assign div_req.start    = (state_q == ST_MACW) && !issue_s1 && !prod_vld_s2;
	assign div_req.dividend = acc_q;
	assign div_req.divisor  = dv_q;

	icbc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= res_pix_q;
			out_row_q  <= 10'(emit_row_q);
			out_col_q  <= 10'(emit_col_q);
			out_last_q <= (emit_lin_q + 1'b1 == total_q);
			out_dz_q   <= res_dz_q;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_pixel = out_pix_q;
	assign out_ch.out_row   = out_row_q;
	assign out_ch.out_col   = out_col_q;
	assign out_ch.out_last  = out_last_q;
	assign out_ch.div_zero  = out_dz_q;

	`include "image_convolution_border_clamp_macros.svh"

	`ICBC_ASSERT_NEXT(a_load_lands, out_load, out_valid_q, "result not presented")
	`ICBC_ASSERT_NOW(a_div_done_state, div_rsp.done, state_q == ST_DIV, "stray divide done")
	`ICBC_ASSERT_NEXT(a_pixel_checks, in_xfer && in_ch.mode == MODE_PIXEL,
		state_q == ST_CHECK, "pixel transfer skipped emit check")
	`ICBC_ASSERT_NOW(a_dz_border, out_load && res_dz_q, dv_q == '0, "div_zero without zero divisor")
endmodule

@@ rtl/icbc_div.sv @@
// Serial signed divider with truncation and clamp to 0..255
module icbc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  icbc_pkg::div_req_t req,
	output icbc_pkg::div_rsp_t rsp
);
	import icbc_pkg::*;

	localparam int CW = $clog2(ACC_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [15:0]      rem_q;
	logic [ACC_W-1:0] quo_q;
	logic [15:0]      dmag_q;
	logic             neg_q;
	logic [16:0]      shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[ACC_W-1]};
	assign fits    = shifted >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ACC_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quo_q  <= req.dividend[ACC_W-1] ? ACC_W'(-req.dividend) : req.dividend;
			dmag_q <= req.divisor[15] ? 16'(-req.divisor) : req.divisor;
			neg_q  <= req.dividend[ACC_W-1] ^ req.divisor[15];
		end else if (busy_q) begin
			rem_q <= fits ? 16'(shifted - {1'b0, dmag_q}) : shifted[15:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (neg_q && quo_q != '0)
			rsp.pix = 8'd0;
		else if (quo_q > ACC_W'(PIX_MAX))
			rsp.pix = PIX_MAX;
		else
			rsp.pix = quo_q[7:0];
	end
endmodule

@@ sim/image_convolution_border_clamp_test.sv @@
// Testbench for the streaming border-clamped image convolution block
`timescale 1ns / 1ps

module image_convolution_border_clamp_test;
	import icbc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int LMAX_W = 1024;
	localparam int LMAX_H = 1024;
	localparam int LMAX_N = 9;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [7:0] pix;
		logic [9:0] row;
		logic [9:0] col;
		logic       last;
		logic       dz;
	} px_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	icbc_in_if  in_ch ();
	icbc_out_if out_ch ();

	image_convolution_border_clamp i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	// shadow state of the filter
	logic [3:0]         sh_order;
	logic [10:0]        sh_width;
	logic [10:0]        sh_height;
	logic signed [15:0] sh_div;
	logic [7:0]         px_mem [LMAX_N*LMAX_W];
	shortint            kern_mem [LMAX_N*LMAX_N];
	int unsigned        coef_ptr;
	int unsigned        rd_row, rd_col, wr_row, wr_col;

	px_result_t pixel_exp_q [$];
	int         mismatches;
	int         hold_cycles;
	bit         idle_on;

	always #4 clk = ~clk;

	initial begin
		#20_000_000;
		$display("image_convolution_border_clamp_test: errors");
		$finish;
	end

	function automatic int unsigned eff_order();
		int unsigned n;
		n = sh_order | 4'd1;
		if (n < 3) n = 3;
		if (n > ((LMAX_N - 1) | 1)) n = (LMAX_N - 1) | 1;
		return n;
	endfunction

	function automatic int unsigned eff_width();
		if (sh_width < 1) return 1;
		return (sh_width > LMAX_W) ? LMAX_W : sh_width;
	endfunction

	function automatic int unsigned eff_height();
		if (sh_height < 1) return 1;
		return (sh_height > LMAX_H) ? LMAX_H : sh_height;
	endfunction

	function automatic void restart_frame();
		rd_row = 0; rd_col = 0; wr_row = 0; wr_col = 0;
	endfunction

	function automatic int unsigned pix_at(int unsigned r, int unsigned c);
		return px_mem[(r % LMAX_N) * LMAX_W + (c % LMAX_W)];
	endfunction

	// computes the next filtered pixel if its window is complete
	function automatic bit filter_next(output px_result_t res);
		int unsigned w, h, n, rad, total, rx, ex, need, r, c, pix;
		longint acc, q;
		bit dz;
		w = eff_width(); h = eff_height(); n = eff_order();
		rad = (n - 1) / 2;
		total = w * h;
		rx = rd_row * w + rd_col;
		ex = wr_row * w + wr_col;
		need = ex + rad * w + rad + 1;
		r = wr_row; c = wr_col; dz = 0;
		if (ex >= total) return 0;
		if (need > total) need = total;
		if (rx < need) return 0;
		if (r < rad || c < rad || r + rad >= h || c + rad >= w) begin
			pix = pix_at(r, c);
		end else if (sh_div == 0) begin
			pix = 0; dz = 1;
		end else begin
			acc = 0;
			for (int kr = 0; kr < n; kr++)
				for (int kc = 0; kc < n; kc++)
					acc += longint'(pix_at(r + kr - rad, c + kc - rad)) *
						longint'(kern_mem[kr * n + kc]);
			q = acc / longint'(sh_div);
			pix = (q < 0) ? 0 : ((q > 255) ? 255 : int'(q));
		end
		res.pix = pix[7:0];
		res.row = r[9:0];
		res.col = c[9:0];
		res.last = (ex + 1 == total);
		res.dz = dz;
		wr_col++;
		if (wr_col >= w) begin
			wr_col = 0; wr_row++;
		end
		if (wr_row >= h) restart_frame();
		return 1;
	endfunction

	function automatic void predict_item(logic [1:0] mode, logic [15:0] val);
		px_result_t res;
		int unsigned w, h;
		case (mode)
			MODE_COEF: begin
				if (coef_ptr < LMAX_N * LMAX_N) kern_mem[coef_ptr] = shortint'(val);
				coef_ptr++;
				if (coef_ptr >= eff_order() * eff_order()) coef_ptr = 0;
			end
			MODE_PIXEL, MODE_DRAIN: begin
				if (mode == MODE_PIXEL) begin
					w = eff_width(); h = eff_height();
					if (rd_row < h) begin
						px_mem[(rd_row % LMAX_N) * LMAX_W + (rd_col % LMAX_W)] = val[7:0];
						rd_col++;
						if (rd_col >= w) begin
							rd_col = 0; rd_row++;
						end
					end
				end
				if (filter_next(res)) pixel_exp_q.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 15) : 0;
	endfunction

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_item(logic [1:0] mode, logic [15:0] val);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.in_value <= val;
		do @(posedge clk); while (!in_ch.ready);
		predict_item(mode, val);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pixel_exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_ORDER: begin
				sh_order = data[3:0]; coef_ptr = 0; restart_frame();
			end
			REG_WIDTH: begin
				sh_width = data[10:0]; restart_frame();
			end
			REG_HEIGHT: begin
				sh_height = data[10:0]; restart_frame();
			end
			default: sh_div = data;
		endcase
	endtask

	// upper data bits beyond each register are don't-care; keep them random
	task automatic setup(int order, int w, int h, int dv);
		logic [15:0] junk;
		wait_idle();
		junk = 16'($urandom);
		cfg_write(REG_ORDER, {junk[15:4], 4'(order)});
		cfg_write(REG_WIDTH, {junk[15:11], 11'(w)});
		cfg_write(REG_HEIGHT, {junk[15:11], 11'(h)});
		cfg_write(REG_DIV, 16'(dv));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2, 3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 12)) - 4);
		endcase
	endfunction

	function automatic int pick_div();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2: return -$signed($urandom_range(1, 40));
			3, 4: return $urandom_range(0, 65535);
			default: return $urandom_range(1, 60);
		endcase
	endfunction

	task automatic load_kernel(int count);
		for (int i = 0; i < count; i++) send_item(MODE_COEF, pick_coef());
	endtask

	// one frame of random pixels, then flush with drains or surplus pixels
	task automatic run_frame(int noise);
		int total;
		logic [15:0] v;
		total = eff_width() * eff_height();
		for (int i = 0; i < total; i++) begin
			if ($urandom_range(0, 99) < noise)
				send_item($urandom_range(0, 1) ? MODE_UNUSED : MODE_DRAIN, 16'($urandom));
			v = 16'($urandom);
			case ($urandom_range(0, 7))
				0: v[7:0] = 8'h00;
				1: v[7:0] = 8'hFF;
				default: ;
			endcase
			send_item(MODE_PIXEL, v);
		end
		while (rd_row != 0 || rd_col != 0 || wr_row != 0 || wr_col != 0)
			send_item($urandom_range(0, 3) == 0 ? MODE_PIXEL : MODE_DRAIN, 16'($urandom));
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_reset_defaults();
		// 640x480 at reset: nothing has its window yet
		send_item(MODE_DRAIN, 16'h0000);
		for (int i = 0; i < 5; i++) send_item(MODE_PIXEL, 16'($urandom));
		send_item(MODE_UNUSED, 16'hFFFF);
		send_item(MODE_DRAIN, 16'hFFFF);
	endtask

	task automatic test_geometry_extremes();
		setup(4'hF, 11'h7FF, 1, 1);          // order clamps to 9, width to 1024
		load_kernel(81);
		run_frame(0);
		setup(0, 0, 0, 1);                   // order 3, single pixel frame
		load_kernel(9);
		run_frame(0);
		for (int o = 1; o < 16; o++)
			setup(o, 12, 11, 7);
		load_kernel(eff_order() * eff_order());
		run_frame(0);
	endtask

	task automatic test_divisors();
		int dv [5] = '{0, -32768, 32767, -1, 1};
		foreach (dv[i]) begin
			setup(3, 5, 4, dv[i]);
			load_kernel(9);
			run_frame(0);
		end
	endtask

	task automatic test_coef_wrap();
		setup(5, 7, 6, 3);
		load_kernel(25 + 11);                // wraps into the first coefficients
		run_frame(0);
	endtask

	task automatic test_backpressure();
		setup(3, 16, 6, 2);
		load_kernel(9);
		idle_on = 0;
		hold_cycles = 1500;
		run_frame(0);
		idle_on = 1;
	endtask

	task automatic test_random();
		int sent;
		int orders [4] = '{3, 5, 7, 9};
		sent = 0;
		while (sent < 300) begin
			int n, w, h;
			n = orders[$urandom_range(0, 3)];
			w = $urandom_range(1, 20);
			h = $urandom_range(1, 12);
			idle_on = $urandom_range(0, 3) != 0;
			setup(n, w, h, pick_div());
			load_kernel(n * n);
			run_frame($urandom_range(0, 4) == 0 ? 10 : 0);
			sent += n * n + w * h;
		end
	endtask

	// ------------------------------------------------------------ receiver

	initial begin
		px_result_t want;
		int gap;
		gap = 0;
		out_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (pixel_exp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel row %0d col %0d value %0d",
							out_ch.out_row, out_ch.out_col, out_ch.out_pixel);
				end else begin
					want = pixel_exp_q.pop_front();
					if (out_ch.out_pixel !== want.pix || out_ch.out_row !== want.row ||
						out_ch.out_col !== want.col || out_ch.out_last !== want.last ||
						out_ch.div_zero !== want.dz) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp pix %0d r %0d c %0d last %0b dz %0b, got pix %0d r %0d c %0d last %0b dz %0b",
								want.pix, want.row, want.col, want.last, want.dz,
								out_ch.out_pixel, out_ch.out_row, out_ch.out_col,
								out_ch.out_last, out_ch.div_zero);
					end
				end
				gap = draw_gap();
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- main

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ORDER;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_DRAIN;
		in_ch.in_value = '0;
		mismatches = 0;
		hold_cycles = 0;
		idle_on = 1;
		sh_order = 4'd3; sh_width = 11'd640; sh_height = 11'd480; sh_div = 16'sd1;
		coef_ptr = 0;
		restart_frame();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_geometry_extremes();
		test_divisors();
		test_coef_wrap();
		test_backpressure();
		test_random();

		wait_idle();
		if (mismatches == 0 && pixel_exp_q.size() == 0)
			$display("image_convolution_border_clamp_test: clean");
		else
			$display("image_convolution_border_clamp_test: errors");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/icbc_pkg.sv
rtl/icbc_if.sv
rtl/icbc_div.sv
rtl/image_convolution_border_clamp.sv
sim/image_convolution_border_clamp_test.sv
